FILE: src/injection_fill_pack_sequencer_core_defines.svh
// Assertion macros for the checker file of the sequencer core.
`ifndef INJECTION_FILL_PACK_SEQUENCER_CORE_DEFINES_SVH
`define INJECTION_FILL_PACK_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define IFPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define IFPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ifps_pkg.sv
// Types, codes and constants of the injection fill/pack sequencer.
`default_nettype none
package ifps_pkg;

	// Stroke timing and volume scaling
	localparam int unsigned TURNS_PER_VOLUME_Q16 = 65536;
	localparam int unsigned STABLE_TIME_MS       = 200;
	localparam int unsigned FILL_TIMEOUT_MS      = 10000;
	localparam int          TPV_W                = 25;
	localparam int          NEED_W               = 32 + TPV_W;
	localparam int          TURNS_W              = NEED_W - 16;

	// Input commands
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_RESET  = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	// Stroke phases
	localparam logic [1:0] PH_DONE = 2'd0;
	localparam logic [1:0] PH_FILL = 2'd1;
	localparam logic [1:0] PH_PACK = 2'd2;

	// Result item kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_LIMITS = 2'd1;
	localparam logic [1:0] KIND_TRAJ   = 2'd2;
	localparam logic [1:0] KIND_MOVE   = 2'd3;

	// Motion profiles
	localparam logic [1:0] PROF_FILL   = 2'd0;
	localparam logic [1:0] PROF_PACK   = 2'd1;
	localparam logic [1:0] PROF_TORQUE = 2'd2;
	localparam logic [1:0] PROF_STOP   = 2'd3;

	// Motor control and input modes
	localparam logic [2:0] CTRL_TORQUE      = 3'd1;
	localparam logic [2:0] CTRL_VELOCITY    = 3'd2;
	localparam logic [2:0] CTRL_POSITION    = 3'd3;
	localparam logic [2:0] INMODE_PASSTHRU  = 3'd1;
	localparam logic [2:0] INMODE_TRAP_TRAJ = 3'd5;
	localparam logic [2:0] INMODE_TQ_RAMP   = 3'd6;

	// Configuration register indexes
	localparam logic [2:0] REG_TORQUE_MODE   = 3'd0;
	localparam logic [2:0] REG_FILL_VOLUME   = 3'd1;
	localparam logic [2:0] REG_PACK_VOLUME   = 3'd2;
	localparam logic [2:0] REG_PACK_TIME_MS  = 3'd3;
	localparam logic [2:0] REG_INJECT_TORQUE = 3'd4;
	localparam logic [2:0] REG_BOTTOM_LIMIT  = 3'd5;
	localparam logic [2:0] REG_VEL_THRESHOLD = 3'd6;
	localparam logic [2:0] REG_POS_TOLERANCE = 3'd7;

	typedef struct packed {
		logic        torque_mode;
		logic [31:0] fill_volume;
		logic [31:0] pack_volume;
		logic [15:0] pack_time_ms;
		logic [31:0] inject_torque;
		logic [31:0] bottom_limit_pos;
		logic [30:0] velocity_threshold;
		logic [30:0] position_tolerance;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] now_ms;
		logic [31:0] measured_pos;
		logic [31:0] measured_vel;
		logic        motor_ready;
		logic [31:0] zero_pos;
		logic        move_ok;
	} sample_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic        entry_pending;
		logic        stroke_complete;
		logic        stroke_error;
		logic [31:0] phase_start_ms;
		logic [31:0] fill_target;
	} state_t;

	// Result items of one input: ncmd command items, then the status item
	typedef struct packed {
		logic [1:0]  ncmd;
		logic [1:0]  profile;
		logic [2:0]  control_mode;
		logic [2:0]  input_mode;
		logic [31:0] setpoint;
		logic        finished;
		logic        failed;
		logic [1:0]  phase_now;
	} burst_t;

endpackage
`default_nettype wire

FILE: src/ifps_step.sv
// Decision logic for one input item: next stroke state and its result items.
`default_nettype none
module ifps_step
	import ifps_pkg::*;
(
	input  cfg_t    cfg,
	input  state_t  cur,
	input  sample_t smp,
	output state_t  nxt,
	output burst_t  burst
);

	localparam logic [TPV_W-1:0] TPV_K = TPV_W'(TURNS_PER_VOLUME_Q16);

	logic [NEED_W-1:0]   fill_need;
	logic [NEED_W-1:0]   pack_need;
	logic signed [57:0]  room;
	logic signed [57:0]  need_s;
	logic signed [41:0]  fill_sum;
	logic signed [41:0]  pack_sum;
	logic signed [41:0]  bottom_x;
	logic [31:0]         fill_tgt;
	logic [31:0]         pack_tgt;
	logic signed [32:0]  vel_x;
	logic [32:0]         vel_mag;
	logic signed [32:0]  pos_err;
	logic [32:0]         err_mag;
	logic [31:0]         elapsed;
	logic                vlow;
	logic                close;
	logic                stable;
	logic                too_big;

	// Volume to turns: scale by the constant, keep the integer turns
	assign fill_need = NEED_W'(cfg.fill_volume) * NEED_W'(TPV_K);
	assign pack_need = NEED_W'(cfg.pack_volume) * NEED_W'(TPV_K);

	// Fit check against the room left below the bottom limit
	assign room    = 58'($signed({cfg.bottom_limit_pos[31], cfg.bottom_limit_pos})
		- $signed({smp.zero_pos[31], smp.zero_pos})) <<< 16;
	assign need_s  = $signed({1'b0, fill_need});
	assign too_big = need_s > room;

	// Clamped fill and pack targets
	assign bottom_x = 42'($signed(cfg.bottom_limit_pos));
	assign fill_sum = 42'($signed(smp.zero_pos)) + $signed({1'b0, fill_need[NEED_W-1:16]});
	assign pack_sum = 42'($signed(smp.measured_pos))
		+ $signed({1'b0, pack_need[NEED_W-1:16]});
	assign fill_tgt = (fill_sum > bottom_x) ? cfg.bottom_limit_pos : fill_sum[31:0];
	assign pack_tgt = (pack_sum > bottom_x) ? cfg.bottom_limit_pos : pack_sum[31:0];

	// Settled velocity and distance to the fill target
	assign vel_x   = 33'($signed(smp.measured_vel));
	assign vel_mag = vel_x[32] ? 33'(-vel_x) : 33'(vel_x);
	assign vlow    = vel_mag < {2'b00, cfg.velocity_threshold};
	assign pos_err = 33'($signed(smp.measured_pos)) - 33'($signed(cur.fill_target));
	assign err_mag = pos_err[32] ? 33'(-pos_err) : 33'(pos_err);
	assign close   = err_mag < {2'b00, cfg.position_tolerance};

	assign elapsed = smp.now_ms - cur.phase_start_ms;
	assign stable  = elapsed > 32'(STABLE_TIME_MS);

	always_comb begin
		nxt                = cur;
		burst              = '0;
		case (smp.cmd)
			CMD_START: begin
				nxt.phase           = PH_FILL;
				nxt.entry_pending   = 1'b1;
				nxt.stroke_complete = 1'b0;
				nxt.stroke_error    = 1'b0;
				nxt.phase_start_ms  = '0;
			end
			CMD_RESET: begin
				nxt.phase           = PH_DONE;
				nxt.entry_pending   = 1'b1;
				nxt.stroke_complete = 1'b0;
				nxt.stroke_error    = 1'b0;
			end
			CMD_SAMPLE: begin
				if (cur.entry_pending) begin
					// Entry: check fit (position mode), latch the fill target, command the fill or torque move
					if (smp.motor_ready) begin
						if (!cfg.torque_mode && too_big) begin
							nxt.stroke_error    = 1'b1;
							nxt.stroke_complete = 1'b1;
							nxt.entry_pending   = 1'b0;
						end else begin
							if (!cfg.torque_mode) begin
								nxt.fill_target    = fill_tgt;
								burst.ncmd         = 2'd3;
								burst.profile      = PROF_FILL;
								burst.control_mode = CTRL_POSITION;
								burst.input_mode   = INMODE_TRAP_TRAJ;
								burst.setpoint     = fill_tgt;
							end else begin
								nxt.fill_target    = '0;
								burst.ncmd         = 2'd2;
								burst.profile      = PROF_TORQUE;
								burst.control_mode = CTRL_TORQUE;
								burst.input_mode   = INMODE_TQ_RAMP;
								burst.setpoint     = cfg.inject_torque;
							end
							if (smp.move_ok) begin
								nxt.phase_start_ms = smp.now_ms;
								nxt.entry_pending  = 1'b0;
							end
						end
					end
				end else if (cur.phase == PH_FILL) begin
					if (cfg.torque_mode) begin
						// Torque fill ends once motion has settled
						if (vlow && stable) begin
							burst.ncmd          = 2'd1;
							burst.profile       = PROF_STOP;
							burst.control_mode  = CTRL_TORQUE;
							burst.input_mode    = INMODE_TQ_RAMP;
							nxt.phase           = PH_DONE;
							nxt.stroke_complete = 1'b1;
						end
					end else if (vlow && (close || stable)) begin
						// Switch over to pack
						nxt.phase          = PH_PACK;
						nxt.phase_start_ms = smp.now_ms;
						burst.ncmd         = 2'd3;
						burst.profile      = PROF_PACK;
						burst.control_mode = CTRL_POSITION;
						burst.input_mode   = INMODE_TRAP_TRAJ;
						burst.setpoint     = pack_tgt;
					end else if (elapsed > 32'(FILL_TIMEOUT_MS)) begin
						// Fill timed out: stop and flag the error
						nxt.stroke_error    = 1'b1;
						nxt.stroke_complete = 1'b1;
						nxt.phase           = PH_DONE;
						burst.ncmd          = 2'd1;
						burst.profile       = PROF_STOP;
						burst.control_mode  = CTRL_VELOCITY;
						burst.input_mode    = INMODE_PASSTHRU;
					end
				end else if (cur.phase == PH_PACK) begin
					if (elapsed >= {16'd0, cfg.pack_time_ms}) begin
						nxt.phase           = PH_DONE;
						nxt.stroke_complete = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		burst.finished  = nxt.stroke_complete;
		burst.failed    = nxt.stroke_error;
		burst.phase_now = nxt.phase;
	end

endmodule
`default_nettype wire

FILE: src/ifps_burst.sv
// Result register and serializer: sends the command items, then the status item.
`default_nettype none
module ifps_burst
	import ifps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  burst_t           in_burst,
	output logic             in_ready,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // profile, control_mode, input_mode, setpoint,
	                                        // finished, failed, phase_now, zero fill
	output logic [1:0]       m_axis_tuser,  // item_kind
	output logic             m_axis_tlast
);

	burst_t     burst_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic       at_status;
	logic       at_move;
	logic       load;

	assign at_status = idx_q == burst_s2.ncmd;
	assign at_move   = (idx_q + 2'd1) == burst_s2.ncmd;
	assign in_ready  = !valid_s2 || (m_axis_tready && at_status);
	assign load      = in_valid && in_ready;

	// Hold the burst; advance one item per accepted output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (valid_s2 && m_axis_tready) begin
			if (at_status) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_s2 <= in_burst;
		end
	end

	// Build the current item from the burst and the item index
	always_comb begin
		m_axis_tvalid = valid_s2;
		m_axis_tlast  = at_status;
		m_axis_tdata  = '0;
		if (at_status) begin
			m_axis_tuser        = KIND_STATUS;
			m_axis_tdata[40]    = burst_s2.finished;
			m_axis_tdata[41]    = burst_s2.failed;
			m_axis_tdata[43:42] = burst_s2.phase_now;
		end else if (at_move) begin
			m_axis_tuser       = KIND_MOVE;
			m_axis_tdata[1:0]  = burst_s2.profile;
			m_axis_tdata[4:2]  = burst_s2.control_mode;
			m_axis_tdata[7:5]  = burst_s2.input_mode;
			m_axis_tdata[39:8] = burst_s2.setpoint;
		end else begin
			m_axis_tuser      = (idx_q == 2'd0) ? KIND_LIMITS : KIND_TRAJ;
			m_axis_tdata[1:0] = burst_s2.profile;
		end
	end

endmodule
`default_nettype wire

FILE: src/injection_fill_pack_sequencer_core.sv
// Top level of the injection fill/pack sequencer.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser cmd, tdata sample fields
//  m_axis    out  tvalid/tready, tlast      tuser item_kind, tdata command/status
//  cfg       in   cfg_we (no wait)          cfg_addr register index, cfg_data value
//
// An item is registered on entry and decided combinationally from the input
// register; its results go into the result register once that is free, and are
// shown from there. Each item yields one to four results, sent one per cycle
// while m_axis_tready is high by the output serializer, which takes the next
// item's results as the status item of the one before is accepted. The input register takes the
// next item while results wait. arst_n clears the stroke state, configuration
// and handshakes. A stall on m_axis holds the current result unchanged.
`default_nettype none
module injection_fill_pack_sequencer_core
	import ifps_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,  // now_ms, measured_pos, measured_vel,
	                                         // motor_ready, zero_pos, move_ok, zero fill
	input  wire logic [1:0]   s_axis_tuser,  // cmd
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [47:0]       m_axis_tdata,  // profile, control_mode, input_mode, setpoint,
	                                         // finished, failed, phase_now, zero fill
	output logic [1:0]        m_axis_tuser,  // item_kind
	output logic              m_axis_tlast,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_addr,
	input  wire logic [31:0]  cfg_data
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	sample_t item_s1;
	logic    valid_s1;
	burst_t  burst;
	logic    burst_ready;
	logic    take_s1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TORQUE_MODE:   cfg_q.torque_mode        <= cfg_data[0];
				REG_FILL_VOLUME:   cfg_q.fill_volume        <= cfg_data;
				REG_PACK_VOLUME:   cfg_q.pack_volume        <= cfg_data;
				REG_PACK_TIME_MS:  cfg_q.pack_time_ms       <= cfg_data[15:0];
				REG_INJECT_TORQUE: cfg_q.inject_torque      <= cfg_data;
				REG_BOTTOM_LIMIT:  cfg_q.bottom_limit_pos   <= cfg_data;
				REG_VEL_THRESHOLD: cfg_q.velocity_threshold <= cfg_data[30:0];
				REG_POS_TOLERANCE: cfg_q.position_tolerance <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// Input register
	assign take_s1       = valid_s1 && burst_ready;
	assign s_axis_tready = !valid_s1 || burst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.cmd          <= s_axis_tuser;
			item_s1.now_ms       <= s_axis_tdata[31:0];
			item_s1.measured_pos <= s_axis_tdata[63:32];
			item_s1.measured_vel <= s_axis_tdata[95:64];
			item_s1.motor_ready  <= s_axis_tdata[96];
			item_s1.zero_pos     <= s_axis_tdata[128:97];
			item_s1.move_ok      <= s_axis_tdata[129];
		end
	end

	ifps_step u_step (
		.cfg   (cfg_q),
		.cur   (state_q),
		.smp   (item_s1),
		.nxt   (state_nxt),
		.burst (burst)
	);

	// Commit the stroke state as the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take_s1) begin
			state_q <= state_nxt;
		end
	end

	ifps_burst u_burst (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (valid_s1),
		.in_burst      (burst),
		.in_ready      (burst_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

FILE: src/ifps_checker.sv
// Port-level checker for the sequencer core, bound to the top level.
`default_nettype none
`include "injection_fill_pack_sequencer_core_defines.svh"
module ifps_checker
	import ifps_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [47:0]  m_axis_tdata,
	input wire logic [1:0]   m_axis_tuser,
	input wire logic         m_axis_tlast
);

	// Hold a stalled result
	`IFPS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed under stall")

	// The status item, and only it, closes the results of an item
	`IFPS_ASSERT_IMP(a_last_is_status, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == KIND_STATUS), "tlast does not match status kind")

	// Command items carry no status bits
	`IFPS_ASSERT_IMP(a_cmd_no_status, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[47:40] == 8'd0, "status bits set on a command item")

	// An accepted item is followed by a valid result on m_axis
	`IFPS_ASSERT_IMP(a_result_follows, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid, "no result after an accepted item")

endmodule

bind injection_fill_pack_sequencer_core ifps_checker u_ifps_checker (.*);
`default_nettype wire

FILE: tb/sv/ifps_stroke_checker.sv
// Scoreboard for the injection sequencer: predicts every result item and compares it.
`timescale 1ns / 100ps
module ifps_stroke_checker
	import ifps_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,
	input  wire logic [1:0]   s_axis_tuser,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [47:0]  m_axis_tdata,
	input  wire logic [1:0]   m_axis_tuser,
	input  wire logic         m_axis_tlast,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_addr,
	input  wire logic [31:0]  cfg_data,
	output int                outstanding,
	output int                failures
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  profile;
		logic [2:0]  control_mode;
		logic [2:0]  input_mode;
		logic [31:0] setpoint;
		logic        finished;
		logic        failed;
		logic [1:0]  phase_now;
		logic        last;
	} motor_item_t;

	// Shadow copy of the registers and the stroke state
	cfg_t               regs;
	logic [1:0]         phase;
	logic               entry_pending;
	logic               stroke_complete;
	logic               stroke_error;
	logic [31:0]        phase_start_ms;
	logic signed [31:0] start_pos;
	logic signed [31:0] fill_target;
	logic signed [31:0] pack_target;

	motor_item_t motor_items_q[$];

	function automatic longint volume_to_turns(input logic [31:0] vol);
		return longint'((64'(vol) * 64'(TURNS_PER_VOLUME_Q16)) >> 16);
	endfunction

	// Hold targets at or below the bottom limit
	function automatic logic [31:0] clamp_to_bottom(input longint t);
		if (t > longint'($signed(regs.bottom_limit_pos)))
			return regs.bottom_limit_pos;
		return t[31:0];
	endfunction

	task automatic push_command(input logic [1:0] kind, input logic [1:0] prof,
	                            input logic [2:0] ctrl, input logic [2:0] inmode,
	                            input logic [31:0] sp);
		motor_item_t m;
		m = '0;
		m.kind = kind;
		m.profile = prof;
		m.control_mode = ctrl;
		m.input_mode = inmode;
		m.setpoint = sp;
		motor_items_q.push_back(m);
	endtask

	// Work out the motor commands one sample item causes
	task automatic apply_sample(input sample_t smp);
		logic [31:0] elapsed;
		longint      room;
		longint      need;
		longint      speed;
		longint      pos_gap;
		logic        vlow;
		logic        close;
		logic        stable;
		elapsed = smp.now_ms - phase_start_ms;
		if (entry_pending) begin
			if (!smp.motor_ready)
				return;
			start_pos = smp.zero_pos;
			if (!regs.torque_mode) begin
				room = (longint'($signed(regs.bottom_limit_pos)) - longint'(start_pos)) * 65536;
				need = longint'(64'(regs.fill_volume) * 64'(TURNS_PER_VOLUME_Q16));
				if (need > room) begin
					stroke_error = 1'b1;
					stroke_complete = 1'b1;
					entry_pending = 1'b0;
					return;
				end
				fill_target = clamp_to_bottom(longint'(start_pos)
					+ volume_to_turns(regs.fill_volume));
				push_command(KIND_LIMITS, PROF_FILL, '0, '0, '0);
				push_command(KIND_TRAJ, PROF_FILL, '0, '0, '0);
				push_command(KIND_MOVE, PROF_FILL, CTRL_POSITION, INMODE_TRAP_TRAJ, fill_target);
			end else begin
				fill_target = '0;
				push_command(KIND_LIMITS, PROF_TORQUE, '0, '0, '0);
				push_command(KIND_MOVE, PROF_TORQUE, CTRL_TORQUE, INMODE_TQ_RAMP,
					regs.inject_torque);
			end
			if (smp.move_ok) begin
				phase_start_ms = smp.now_ms;
				entry_pending = 1'b0;
			end
			return;
		end

		if (phase == PH_FILL) begin
			speed = longint'($signed(smp.measured_vel));
			if (speed < 0)
				speed = -speed;
			pos_gap = longint'($signed(smp.measured_pos)) - longint'(fill_target);
			if (pos_gap < 0)
				pos_gap = -pos_gap;
			vlow = speed < longint'(regs.velocity_threshold);
			close = pos_gap < longint'(regs.position_tolerance);
			stable = elapsed > STABLE_TIME_MS;
			if (regs.torque_mode) begin
				if (vlow && stable) begin
					push_command(KIND_MOVE, PROF_STOP, CTRL_TORQUE, INMODE_TQ_RAMP, '0);
					phase = PH_DONE;
					stroke_complete = 1'b1;
				end
				return;
			end
			if (vlow && (close || stable)) begin
				phase = PH_PACK;
				phase_start_ms = smp.now_ms;
				pack_target = clamp_to_bottom(longint'($signed(smp.measured_pos))
					+ volume_to_turns(regs.pack_volume));
				push_command(KIND_LIMITS, PROF_PACK, '0, '0, '0);
				push_command(KIND_TRAJ, PROF_PACK, '0, '0, '0);
				push_command(KIND_MOVE, PROF_PACK, CTRL_POSITION, INMODE_TRAP_TRAJ, pack_target);
				return;
			end
			// Fill took too long: stop the motor and flag the stroke
			if (elapsed > FILL_TIMEOUT_MS) begin
				stroke_error = 1'b1;
				stroke_complete = 1'b1;
				phase = PH_DONE;
				push_command(KIND_MOVE, PROF_STOP, CTRL_VELOCITY, INMODE_PASSTHRU, '0);
			end
			return;
		end

		if (phase == PH_PACK && elapsed >= {16'd0, regs.pack_time_ms}) begin
			phase = PH_DONE;
			stroke_complete = 1'b1;
		end
	endtask

	task automatic predict_item(input sample_t smp);
		motor_item_t status;
		case (smp.cmd)
			CMD_START: begin
				phase = PH_FILL;
				entry_pending = 1'b1;
				stroke_complete = 1'b0;
				stroke_error = 1'b0;
				phase_start_ms = '0;
				start_pos = '0;
			end
			CMD_RESET: begin
				phase = PH_DONE;
				entry_pending = 1'b1;
				stroke_complete = 1'b0;
				stroke_error = 1'b0;
			end
			CMD_SAMPLE: apply_sample(smp);
			default: ;
		endcase
		// Every item closes with a status item
		status = '0;
		status.kind = KIND_STATUS;
		status.finished = stroke_complete;
		status.failed = stroke_error;
		status.phase_now = phase;
		status.last = 1'b1;
		motor_items_q.push_back(status);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		case (idx)
			REG_TORQUE_MODE:   regs.torque_mode = value[0];
			REG_FILL_VOLUME:   regs.fill_volume = value;
			REG_PACK_VOLUME:   regs.pack_volume = value;
			REG_PACK_TIME_MS:  regs.pack_time_ms = value[15:0];
			REG_INJECT_TORQUE: regs.inject_torque = value;
			REG_BOTTOM_LIMIT:  regs.bottom_limit_pos = value;
			REG_VEL_THRESHOLD: regs.velocity_threshold = value[30:0];
			REG_POS_TOLERANCE: regs.position_tolerance = value[30:0];
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
	                             input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : watch
		motor_item_t seen;
		motor_item_t want;
		sample_t     smp;
		if (!arst_n) begin
			regs = '0;
			phase = PH_DONE;
			entry_pending = 1'b0;
			stroke_complete = 1'b0;
			stroke_error = 1'b0;
			phase_start_ms = '0;
			start_pos = '0;
			fill_target = '0;
			pack_target = '0;
			failures = 0;
			motor_items_q.delete();
		end else begin
			// Compare each result item with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				seen.kind = m_axis_tuser;
				seen.profile = m_axis_tdata[1:0];
				seen.control_mode = m_axis_tdata[4:2];
				seen.input_mode = m_axis_tdata[7:5];
				seen.setpoint = m_axis_tdata[39:8];
				seen.finished = m_axis_tdata[40];
				seen.failed = m_axis_tdata[41];
				seen.phase_now = m_axis_tdata[43:42];
				seen.last = m_axis_tlast;
				if (motor_items_q.size() == 0) begin
					$error("result item with nothing predicted: kind %0d setpoint 0x%0h",
						seen.kind, seen.setpoint);
					failures++;
				end else begin
					want = motor_items_q.pop_front();
					compare_field("item_kind", want.kind, seen.kind);
					compare_field("profile", want.profile, seen.profile);
					compare_field("control_mode", want.control_mode, seen.control_mode);
					compare_field("input_mode", want.input_mode, seen.input_mode);
					compare_field("setpoint", want.setpoint, seen.setpoint);
					compare_field("finished", want.finished, seen.finished);
					compare_field("failed", want.failed, seen.failed);
					compare_field("phase_now", want.phase_now, seen.phase_now);
					compare_field("last", want.last, seen.last);
				end
			end
			if (cfg_we)
				write_reg(cfg_addr, cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				smp.cmd = s_axis_tuser;
				smp.now_ms = s_axis_tdata[31:0];
				smp.measured_pos = s_axis_tdata[63:32];
				smp.measured_vel = s_axis_tdata[95:64];
				smp.motor_ready = s_axis_tdata[96];
				smp.zero_pos = s_axis_tdata[128:97];
				smp.move_ok = s_axis_tdata[129];
				predict_item(smp);
			end
		end
		outstanding <= motor_items_q.size();
	end

endmodule

FILE: tb/sv/testbench.sv
// Top of the sequencer testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module testbench;
	import ifps_pkg::*;

	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam logic [31:0] ONE         = 32'h0001_0000;
	localparam longint      S32_MIN     = 64'shFFFF_FFFF_8000_0000;
	localparam int          LONG_HOLD   = 300;
	localparam int          QUIET_LIMIT = 3000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [47:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_addr = '0;
	logic [31:0]  cfg_data = '0;

	int   outstanding;
	int   failures;
	int   items_sent = 0;
	int   quiet_cycles = 0;
	int   results_taken;
	int   stall_left;
	int   calm_left;
	bit   sender_calm = 1'b0;
	cfg_t settings = '0;

	injection_fill_pack_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	ifps_stroke_checker stroke_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.failures(failures)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random stalls, two long hold-offs to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			results_taken = 0;
			stall_left = 0;
			calm_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_taken++;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(19) == 0)
					calm_left = 30;
				if (results_taken == 40 || results_taken == 260)
					stall_left = LONG_HOLD;
				else
					stall_left = idle_gap(calm_left > 0);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			m_axis_tready <= (stall_left == 0);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input logic [1:0] cmd, input logic [31:0] now,
	                         input logic [31:0] pos, input logic [31:0] vel,
	                         input logic ready, input logic [31:0] zero, input logic ok);
		int gap;
		gap = idle_gap(sender_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {6'd0, ok, zero, ready, vel, pos, now};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Drain every expected result, then let the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic mode, input logic [31:0] fill,
	                              input logic [31:0] pack, input logic [15:0] hold,
	                              input logic [31:0] torque, input logic [31:0] bottom,
	                              input logic [30:0] vthr, input logic [30:0] tol);
		settings.torque_mode = mode;
		settings.fill_volume = fill;
		settings.pack_volume = pack;
		settings.pack_time_ms = hold;
		settings.inject_torque = torque;
		settings.bottom_limit_pos = bottom;
		settings.velocity_threshold = vthr;
		settings.position_tolerance = tol;
		write_reg(REG_TORQUE_MODE, {31'd0, mode});
		write_reg(REG_FILL_VOLUME, fill);
		write_reg(REG_PACK_VOLUME, pack);
		write_reg(REG_PACK_TIME_MS, {16'd0, hold});
		write_reg(REG_INJECT_TORQUE, torque);
		write_reg(REG_BOTTOM_LIMIT, bottom);
		write_reg(REG_VEL_THRESHOLD, {1'b0, vthr});
		write_reg(REG_POS_TOLERANCE, {1'b0, tol});
		cfg_we <= 1'b0;
	endtask

	// One stroke: arm, entry with possible refusals, then fill and pack samples
	task automatic run_stroke();
		logic [31:0] t;
		logic [31:0] zero;
		logic [31:0] target;
		logic [31:0] vel;
		logic [31:0] pos;
		logic [31:0] mag;
		longint      z;
		int          tries;
		int          sel;
		logic        ok;
		sender_calm = ($urandom_range(3) == 0);
		t = $urandom;
		send_item(($urandom_range(6) == 0) ? CMD_RESET : CMD_START, $urandom, $urandom,
			$urandom, $urandom_range(1), $urandom, $urandom_range(1));
		repeat ($urandom_range(1))
			send_item(CMD_SAMPLE, t, $urandom, $urandom, 1'b0, $urandom, $urandom_range(1));

		// Pick a zero position that mostly lets the fill volume fit
		z = longint'($signed(settings.bottom_limit_pos)) - longint'(settings.fill_volume)
			- longint'($urandom_range(0, 32'h03E8_0000));
		if (z < S32_MIN)
			z = S32_MIN;
		zero = ($urandom_range(4) == 0) ? $urandom : z[31:0];
		target = zero + settings.fill_volume;

		tries = 0;
		do begin
			ok = ($urandom_range(3) != 0) || (tries == 3);
			send_item(CMD_SAMPLE, t, $urandom, $urandom, 1'b1, zero, ok);
			t += $urandom_range(0, 20);
			tries++;
		end while (!ok);

		repeat ($urandom_range(2, 9)) begin
			sel = $urandom_range(9);
			if (sel < 7)
				t += $urandom_range(0, 150);
			else if (sel < 9)
				t += $urandom_range(150, 400);
			else
				t += $urandom_range(9000, 12000);
			if ($urandom_range(1)) begin
				mag = (settings.velocity_threshold == 0) ? '0
					: $urandom_range(0, settings.velocity_threshold - 1);
				vel = $urandom_range(1) ? -mag : mag;
			end else begin
				vel = $urandom;
			end
			if ($urandom_range(1)) begin
				mag = (settings.position_tolerance == 0) ? '0
					: $urandom_range(0, settings.position_tolerance - 1);
				pos = $urandom_range(1) ? target - mag : target + mag;
			end else begin
				pos = $urandom;
			end
			send_item(CMD_SAMPLE, t, pos, vel, $urandom_range(1), $urandom, $urandom_range(1));
			// Occasional noise: any command, any content
			if ($urandom_range(9) == 0)
				send_item($urandom_range(3), $urandom, $urandom, $urandom,
					$urandom_range(1), $urandom, $urandom_range(1));
		end
	endtask

	task automatic run_phase(input int quota);
		int first;
		first = items_sent;
		while (items_sent - first < quota)
			run_stroke();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strokes in position mode
		apply_settings(1'b0, 10 * ONE, 2 * ONE, 16'd50, 32'h8000_0000, 100 * ONE,
			31'(ONE), 31'(ONE / 2));
		send_item(CMD_UNUSED, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'd0, 1'b1);
		// Reset arms an entry while the phase stays done
		send_item(CMD_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			32'hFFFF_FFFF, 1'b1);
		send_item(CMD_SAMPLE, 32'd10, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		// Normal stroke: not ready, refused move, then fill reached and pack held
		send_item(CMD_START, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0);
		send_item(CMD_SAMPLE, 32'd400, 32'd0, 32'd0, 1'b0, 20 * ONE, 1'b1);
		send_item(CMD_SAMPLE, 32'd500, 32'd0, 32'd0, 1'b1, 20 * ONE, 1'b0);
		send_item(CMD_SAMPLE, 32'd1000, 32'd0, 32'd0, 1'b1, 20 * ONE, 1'b1);
		send_item(CMD_SAMPLE, 32'd1100, 25 * ONE, 5 * ONE, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd1150, 30 * ONE + 100, -32'd100, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd1170, 32 * ONE, 32'd0, 1'b1, 32'd0, 1'b0);
		send_item(CMD_SAMPLE, 32'd1200, 32 * ONE, 32'd0, 1'b1, 32'd0, 1'b0);
		// Time wraps; fill leaves on settled velocity after the stable time
		send_item(CMD_START, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'hFFFF_FF00, 32'd0, 32'd0, 1'b1, -50 * ONE, 1'b1);
		send_item(CMD_SAMPLE, 32'h0000_0100, 32'h8000_0000, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'h0000_0200, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0);
		// Fill timeout
		send_item(CMD_START, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd5000, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd15001, 32'd0, 32'h7FFF_FFFF, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd15002, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		// Fill volume does not fit below the bottom limit
		send_item(CMD_START, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd100, 32'd0, 32'd0, 1'b1, 95 * ONE, 1'b1);
		send_item(CMD_SAMPLE, 32'd20000, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);

		// Directed torque stroke
		wait_idle();
		apply_settings(1'b1, 10 * ONE, 2 * ONE, 16'd50, 32'h8000_0000, 100 * ONE,
			31'(ONE), 31'(ONE / 2));
		send_item(CMD_START, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd100, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd400, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
		send_item(CMD_SAMPLE, 32'd410, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);

		// Random strokes: moderate position settings
		wait_idle();
		apply_settings(1'b0, $urandom_range(0, 40 * ONE), $urandom_range(0, 8 * ONE),
			$urandom_range(0, 400), $urandom,
			$urandom_range(0, 2000 * ONE) - 1000 * ONE,
			$urandom_range(ONE / 4, 4 * ONE), $urandom_range(ONE / 8, 2 * ONE));
		run_phase(88);

		// Torque mode with the widest threshold
		wait_idle();
		apply_settings(1'b1, $urandom, $urandom, $urandom_range(0, 65535), 32'h7FFF_FFFF,
			$urandom, 31'h7FFF_FFFF, $urandom_range(0, 32'h7FFF_FFFF));
		run_phase(88);

		// Largest volumes, limits and tolerances
		wait_idle();
		apply_settings(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF);
		run_phase(88);

		// All-zero volumes and thresholds, lowest bottom limit
		wait_idle();
		apply_settings(1'b0, 32'd0, 32'd0, 16'd0, 32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0);
		run_phase(88);

		wait_idle();
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
